// File: sv/pgpd_pkg.sv
`default_nettype none
package pgpd_pkg;

  localparam int PRIME_W        = 48;
  localparam int LIMIT_W        = 24;
  localparam int RUN_W          = 7;
  localparam int CFG_ADDR_W     = 2;
  localparam int CFG_DATA_W     = 48;
  localparam int HALF_W         = 8;
  localparam int CODE_W         = 32;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [LIMIT_W-1:0] PRIME_LIMIT_RST = 24'd1000;
  localparam logic [PRIME_W-1:0] FIRST_PRIME_RST = 48'd3;
  localparam logic [RUN_W-1:0]   RUN_LIMIT_RST   = 7'd100;
  localparam logic [RUN_W-1:0]   RUN_COUNT_MAX   = 7'd127;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PRIME_LIMIT = 2'd0,
    REG_FIRST_PRIME = 2'd1,
    REG_RUN_LIMIT   = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_t;

  // One queued byte plus the run-stop verdict taken when it arrived.
  typedef struct packed {
    logic       run_stop;
    logic [7:0] data;
  } byte_item_t;

  typedef struct packed {
    logic [PRIME_W-1:0] prime;
    logic               prime_valid;
    logic               bad_code;
    logic               done_res;
  } result_t;

  // Codewords are keyed with a leading marker bit above the code, so that
  // the key carries both the length and the bits of the prefix.
  function automatic logic [HALF_W-1:0] code_half(input logic [CODE_W-1:0] key);
    logic [HALF_W-1:0] h;
    h = '0;
    unique case (key)
      32'b110001: h = 8'd1;
      32'b101111: h = 8'd2;
      32'b10101: h = 8'd3;
      32'b100011: h = 8'd4;
      32'b110011: h = 8'd5;
      32'b111011: h = 8'd6;
      32'b1111101: h = 8'd7;
      32'b1110001: h = 8'd8;
      32'b110101: h = 8'd9;
      32'b1110011: h = 8'd10;
      32'b1101101: h = 8'd11;
      32'b100001: h = 8'd12;
      32'b11110111: h = 8'd13;
      32'b1001011: h = 8'd14;
      32'b1111111: h = 8'd15;
      32'b10110101: h = 8'd16;
      32'b10110111: h = 8'd17;
      32'b1001101: h = 8'd18;
      32'b10010011: h = 8'd19;
      32'b10110011: h = 8'd20;
      32'b11110101: h = 8'd21;
      32'b111100001: h = 8'd22;
      32'b110111011: h = 8'd23;
      32'b10110001: h = 8'd24;
      32'b110111101: h = 8'd25;
      32'b100111001: h = 8'd26;
      32'b111100101: h = 8'd27;
      32'b100100001: h = 8'd28;
      32'b1101111111: h = 8'd29;
      32'b111100011: h = 8'd30;
      32'b1001110101: h = 8'd31;
      32'b1001110111: h = 8'd32;
      32'b100100011: h = 8'd33;
      32'b11110011011: h = 8'd34;
      32'b1001111111: h = 8'd35;
      32'b1101110001: h = 8'd36;
      32'b11011100101: h = 8'd37;
      32'b10011110111: h = 8'd38;
      32'b1001111001: h = 8'd39;
      32'b10011111001: h = 8'd40;
      32'b111100110001: h = 8'd41;
      32'b11110011101: h = 8'd42;
      32'b100111110111: h = 8'd43;
      32'b110111110001: h = 8'd44;
      32'b11011100111: h = 8'd45;
      32'b1111001111101: h = 8'd46;
      32'b1111001111001: h = 8'd47;
      32'b110111110101: h = 8'd48;
      32'b1101111101111: h = 8'd49;
      32'b1111001100111: h = 8'd50;
      32'b100111101011: h = 8'd51;
      32'b1001111010001: h = 8'd52;
      32'b11110011110111: h = 8'd53;
      32'b1111001100101: h = 8'd54;
      32'b11110011111111: h = 8'd55;
      32'b11011111011011: h = 8'd56;
      32'b1001111101011: h = 8'd57;
      32'b10011110100111: h = 8'd58;
      32'b10011110100101: h = 8'd59;
      32'b1001111101001: h = 8'd60;
      32'b110111110011101: h = 8'd61;
      32'b110111110110001: h = 8'd62;
      32'b11011111001101: h = 8'd63;
      32'b1111001111110111: h = 8'd64;
      32'b110111110010111: h = 8'd65;
      32'b111100111111001: h = 8'd66;
      32'b1101111101100111: h = 8'd67;
      32'b1101111100111111: h = 8'd68;
      32'b110111110010101: h = 8'd69;
      32'b1111001111010011: h = 8'd70;
      32'b11110011111101011: h = 8'd71;
      32'b1111001111010111: h = 8'd72;
      32'b11011111011001011: h = 8'd73;
      32'b11110011110100011: h = 8'd74;
      32'b1111001111010101: h = 8'd75;
      32'b11011111001001001: h = 8'd76;
      32'b11011111001111011: h = 8'd77;
      32'b1101111100100001: h = 8'd78;
      32'b111100111101000011: h = 8'd79;
      32'b11011111001000101: h = 8'd80;
      32'b11011111001111001: h = 8'd81;
      32'b110111110010011101: h = 8'd82;
      32'b110111110010001111: h = 8'd83;
      32'b11011111001001101: h = 8'd84;
      32'b110111110010010101: h = 8'd85;
      32'b1111001111110100001: h = 8'd86;
      32'b111100111101000001: h = 8'd87;
      32'b1101111101100100101: h = 8'd88;
      32'b1101111100100101111: h = 8'd89;
      32'b110111110110010001: h = 8'd90;
      32'b1101111100100011011: h = 8'd91;
      32'b11110011111101001001: h = 8'd92;
      32'b1101111101100100111: h = 8'd93;
      32'b11011111001001111001: h = 8'd94;
      32'b11110011111101001011: h = 8'd95;
      32'b1101111100100011001: h = 8'd96;
      32'b111100111111010011011: h = 8'd97;
      32'b111100111111010011101: h = 8'd98;
      32'b11110011111101000111: h = 8'd99;
      32'b111100111111010001011: h = 8'd100;
      32'b110111110010011111101: h = 8'd101;
      32'b11011111001001011011: h = 8'd102;
      32'b1111001111110100111101: h = 8'd103;
      32'b110111110010010110011: h = 8'd104;
      32'b11011111001001111101: h = 8'd105;
      32'b1101111100100111101001: h = 8'd106;
      32'b1101111100100111101011: h = 8'd107;
      32'b1111001111110100111111: h = 8'd108;
      32'b1101111100100101100001: h = 8'd109;
      32'b1101111100100111111101: h = 8'd110;
      32'b1111001111110100010011: h = 8'd111;
      32'b11110011111101001100001: h = 8'd112;
      32'b11011111001001111011111: h = 8'd113;
      32'b1101111100100111101101: h = 8'd114;
      32'b11011111001001111111101: h = 8'd115;
      32'b111100111111010011001001: h = 8'd116;
      32'b11110011111101001100111: h = 8'd117;
      32'b111100111111010001000011: h = 8'd118;
      32'b111100111111010011000111: h = 8'd119;
      32'b11011111001001111111111: h = 8'd120;
      32'b110111110010010110001001: h = 8'd121;
      32'b110111110010010110001011: h = 8'd122;
      32'b111100111111010001000101: h = 8'd123;
      32'b1111001111110100110001011: h = 8'd124;
      32'b1111001111110100010000011: h = 8'd125;
      32'b111100111111010001000111: h = 8'd126;
      32'b11110011111101001100101101: h = 8'd127;
      32'b1101111100100101100011001: h = 8'd128;
      32'b110111110010010110001111: h = 8'd129;
      32'b1101111100100111101110011: h = 8'd130;
      32'b11110011111101000100000001: h = 8'd131;
      32'b1101111100100111101110001: h = 8'd132;
      32'b11110011111101001100010011: h = 8'd133;
      32'b111100111111010011001011101: h = 8'd134;
      32'b1101111100100111101110111: h = 8'd135;
      32'b111100111111010011001010101: h = 8'd136;
      32'b111100111111010011001010011: h = 8'd137;
      32'b11110011111101001100010001: h = 8'd138;
      32'b110111110010011110111010011: h = 8'd139;
      32'b11011111001001011000110101: h = 8'd140;
      32'b111100111111010011001011111: h = 8'd141;
      32'b1111001111110100010000001111: h = 8'd142;
      32'b110111110010011110111010101: h = 8'd143;
      32'b110111110010011110111010111: h = 8'd144;
      32'b111100111111010001000000101: h = 8'd145;
      32'b11110011111101001100101000011: h = 8'd146;
      32'b110111110010010110001101111: h = 8'd147;
      32'b11110011111101001100101000101: h = 8'd148;
      32'b111100111111010011001010111101: h = 8'd149;
      32'b110111110010010110001101101: h = 8'd150;
      32'b111100111111010011001010111111: h = 8'd151;
      32'b11011111001001111011101000101: h = 8'd152;
      32'b11110011111101001100101011101: h = 8'd153;
      32'b111100111111010001000000110001: h = 8'd154;
      32'b111100111111010001000000110011: h = 8'd155;
      32'b11011111001001111011101000001: h = 8'd156;
      32'b1111001111110100110010100000111: h = 8'd157;
      32'b11110011111101001100101011011101: h = 8'd158;
      32'b11110011111101001100101000111: h = 8'd159;
      32'b111100111111010011001010110001: h = 8'd160;
      32'b111100111111010001000000110101: h = 8'd161;
      32'b11110011111101001100101011011111: h = 8'd162;
      32'b111100111111010001000000110111: h = 8'd163;
      32'b1111001111110100110010101100101: h = 8'd164;
      32'b11011111001001111011101000011: h = 8'd165;
      32'b111100111111010011001010000001: h = 8'd166;
      32'b1111001111110100110010101100111: h = 8'd168;
      32'b11011111001001111011101000111: h = 8'd170;
      32'b1111001111110100110010101101001: h = 8'd171;
      32'b1111001111110100110010101101011: h = 8'd173;
      32'b1111001111110100110010101101101: h = 8'd177;
      32'b1111001111110100110010100000101: h = 8'd191;
      default: h = '0;
    endcase
    return h;
  endfunction

endpackage
`default_nettype wire

// File: sv/pgpd_front.sv
`default_nettype none
module pgpd_front import pgpd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  acc,
  input  wire logic [7:0]            data,
  input  wire logic                  lim_we,
  input  wire logic [RUN_W-1:0]      lim_data,
  output byte_item_t                 item
);

  logic [7:0]       prev_r;
  logic [RUN_W-1:0] cnt_r, cnt_nxt;
  logic [RUN_W-1:0] lim_r;

  // Run length including the byte now arriving, saturating.
  always_comb begin
    if (data != prev_r) begin
      cnt_nxt = RUN_W'(1);
    end else if (cnt_r == RUN_COUNT_MAX) begin
      cnt_nxt = cnt_r;
    end else begin
      cnt_nxt = cnt_r + RUN_W'(1);
    end
  end

  assign item.data     = data;
  assign item.run_stop = (cnt_nxt >= lim_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      cnt_r  <= '0;
      lim_r  <= RUN_LIMIT_RST;
    end else begin
      if (acc) begin
        prev_r <= data;
        cnt_r  <= cnt_nxt;
      end
      if (lim_we) begin
        lim_r <= lim_data;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/pgpd_queue.sv
`default_nettype none
module pgpd_queue import pgpd_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  byte_item_t push_item,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output byte_item_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  byte_item_t     mem [DEPTH];
  logic [AW-1:0]  wr_r, rd_r;
  logic [AW:0]    cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wr_r <= (wr_r == AW'(DEPTH-1)) ? '0 : wr_r + AW'(1);
      end
      if (pop && !empty) begin
        rd_r <= (rd_r == AW'(DEPTH-1)) ? '0 : rd_r + AW'(1);
      end
      cnt_r <= cnt_r + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

// File: sv/pgpd_back.sv
`default_nettype none
module pgpd_back import pgpd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  byte_item_t              q_head,
  output logic                    q_pop,
  input  wire logic               lim_we,
  input  wire logic [LIMIT_W-1:0] lim_data,
  input  wire logic               fp_we,
  input  wire logic [PRIME_W-1:0] fp_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output result_t                 out_res,
  output logic                    out_last
);

  logic [7:0]         byte_r, byte_nxt;
  logic [2:0]         bit_r, bit_nxt;
  logic               busy_r, busy_nxt;
  logic               flush_r, flush_nxt;
  logic               rstop_r, rstop_nxt;
  logic               stopped_r, stopped_nxt;
  logic [CODE_W-1:0]  pfx_r, pfx_nxt;
  logic [PRIME_W-1:0] prime_r, prime_nxt;
  logic [LIMIT_W-1:0] left_r, left_nxt;
  logic               pend_v_r, pend_v_nxt;
  result_t            pend_r, pend_nxt;
  logic               ov_r, ov_nxt;
  result_t            ores_r, ores_nxt;
  logic               olast_r, olast_nxt;

  logic               slot_free;
  logic               bad;
  logic [CODE_W-1:0]  key;
  logic [HALF_W-1:0]  half;
  logic [PRIME_W-1:0] sum;
  logic               hit;
  result_t            fin_res;
  logic               fin_v;

  assign slot_free = !ov_r || out_ready;
  // The marker bit at the top means the prefix already holds the longest code.
  assign bad  = pfx_r[CODE_W-1];
  assign key  = {pfx_r[CODE_W-2:0], byte_r[7]};
  assign half = code_half(key);
  assign hit  = !bad && (half != '0);
  assign sum  = prime_r + {{(PRIME_W-HALF_W-1){1'b0}}, half, 1'b0};

  always_comb begin
    byte_nxt    = byte_r;
    bit_nxt     = bit_r;
    busy_nxt    = busy_r;
    flush_nxt   = flush_r;
    rstop_nxt   = rstop_r;
    stopped_nxt = stopped_r;
    pfx_nxt     = pfx_r;
    prime_nxt   = prime_r;
    left_nxt    = left_r;
    pend_v_nxt  = pend_v_r;
    pend_nxt    = pend_r;
    ov_nxt      = slot_free ? 1'b0 : ov_r;
    ores_nxt    = ores_r;
    olast_nxt   = olast_r;
    q_pop       = 1'b0;
    fin_res     = pend_r;
    fin_v       = pend_v_r;

    if (busy_r) begin
      if (!(bad || hit) || !pend_v_r || slot_free) begin
        byte_nxt = {byte_r[6:0], 1'b0};
        bit_nxt  = bit_r + 3'd1;
        if (bit_r == 3'd7) begin
          busy_nxt  = 1'b0;
          flush_nxt = 1'b1;
        end
        if (bad || hit) begin
          if (pend_v_r) begin
            ov_nxt    = 1'b1;
            ores_nxt  = pend_r;
            olast_nxt = 1'b0;
          end
          pend_v_nxt = 1'b1;
          pfx_nxt    = CODE_W'(1);
        end else begin
          pfx_nxt = key;
        end
        if (bad) begin
          pend_nxt = '{prime: prime_r, prime_valid: 1'b0, bad_code: 1'b1, done_res: 1'b0};
        end else if (hit) begin
          prime_nxt = sum;
          pend_nxt  = '{prime: sum, prime_valid: 1'b1, bad_code: 1'b0,
                        done_res: (left_r <= LIMIT_W'(1))};
          if (left_r <= LIMIT_W'(1)) begin
            left_nxt    = '0;
            stopped_nxt = 1'b1;
            busy_nxt    = 1'b0;
            flush_nxt   = 1'b1;
          end else begin
            left_nxt = left_r - LIMIT_W'(1);
          end
        end
      end
    end else if (flush_r) begin
      if (!stopped_r && rstop_r) begin
        fin_v            = 1'b1;
        fin_res.done_res = 1'b1;
        if (!pend_v_r) begin
          fin_res = '{prime: prime_r, prime_valid: 1'b0, bad_code: 1'b0, done_res: 1'b1};
        end
      end
      if (!fin_v || slot_free) begin
        flush_nxt  = 1'b0;
        pend_v_nxt = 1'b0;
        if (!stopped_r && rstop_r) begin
          stopped_nxt = 1'b1;
        end
        if (fin_v) begin
          ov_nxt    = 1'b1;
          ores_nxt  = fin_res;
          olast_nxt = 1'b1;
        end
      end
    end else if (!q_empty) begin
      q_pop = 1'b1;
      if (!stopped_r) begin
        byte_nxt  = q_head.data;
        rstop_nxt = q_head.run_stop;
        bit_nxt   = '0;
        busy_nxt  = 1'b1;
      end
    end

    if (lim_we) begin
      left_nxt = lim_data;
    end
    if (fp_we) begin
      prime_nxt = fp_data;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    bit_r   <= bit_nxt;
    rstop_r <= rstop_nxt;
    pend_r  <= pend_nxt;
    ores_r  <= ores_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      flush_r   <= 1'b0;
      stopped_r <= 1'b0;
      pfx_r     <= CODE_W'(1);
      prime_r   <= FIRST_PRIME_RST;
      left_r    <= PRIME_LIMIT_RST;
      pend_v_r  <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      flush_r   <= flush_nxt;
      stopped_r <= stopped_nxt;
      pfx_r     <= pfx_nxt;
      prime_r   <= prime_nxt;
      left_r    <= left_nxt;
      pend_v_r  <= pend_v_nxt;
      ov_r      <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_res   = ores_r;
  assign out_last  = olast_r;

endmodule
`default_nettype wire

// File: sv/prime_gap_prefix_decoder.sv
`default_nettype none
// Channel   | Direction | Handshake          | Payload
// in_       | input     | in_tvalid/tready   | tdata[7:0] = data_byte
// out_      | output    | out_tvalid/tready  | tdata = prime, tuser = flags, tlast
// cfg_      | input     | cfg_we             | cfg_addr selects register, cfg_wdata
//
// In the decoding engine a byte is loaded from the queue, its bits are shifted
// one per cycle through the codeword match while no finished code waits on
// a stalled result register, and the byte is closed out before the next is loaded.
// Bytes are taken every cycle while the queue has room.
// Reset is synchronous and active low; it restores the register defaults.
// A stalled result register holds the engine only when a new result must
// be pushed; the front keeps taking bytes until the queue fills.
module prime_gap_prefix_decoder import pgpd_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [7:0]              in_tdata,   // [7:0] data_byte
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  output logic [PRIME_W-1:0]           out_tdata,  // [47:0] prime
  output logic [2:0]                   out_tuser,  // [0] prime_valid, [1] bad_code, [2] done_res
  output logic                         out_tlast,  // last_of_run
  input  wire logic                    cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata
);

  byte_item_t push_item, head;
  logic       full, empty, pop, acc;
  result_t    res;
  logic       lim_we, fp_we, run_we;

  assign in_tready = !full;
  assign acc       = in_tvalid && !full;

  // Register decode: each write also loads the working copy.
  always_comb begin
    lim_we = 1'b0;
    fp_we  = 1'b0;
    run_we = 1'b0;
    unique case (cfg_reg_t'(cfg_addr))
      REG_PRIME_LIMIT: lim_we = cfg_we;
      REG_FIRST_PRIME: fp_we  = cfg_we;
      REG_RUN_LIMIT:   run_we = cfg_we;
      default: ;
    endcase
  end

  pgpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .data     (in_tdata),
    .lim_we   (run_we),
    .lim_data (cfg_wdata[RUN_W-1:0]),
    .item     (push_item)
  );

  pgpd_queue #(.DEPTH(FIFO_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  pgpd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (empty),
    .q_head    (head),
    .q_pop     (pop),
    .lim_we    (lim_we),
    .lim_data  (cfg_wdata[LIMIT_W-1:0]),
    .fp_we     (fp_we),
    .fp_data   (cfg_wdata[PRIME_W-1:0]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .out_last  (out_tlast)
  );

  assign out_tdata = res.prime;
  assign out_tuser = {res.done_res, res.bad_code, res.prime_valid};

endmodule
`default_nettype wire

// File: tb/tb_prime_gap_prefix_decoder.sv
`timescale 1ns / 1ps

module tb_prime_gap_prefix_decoder;
  import pgpd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  // Room for a full queue to pass through the engine, with margin.
  localparam int DRAIN_CYCLES = 120;
  localparam int N_CODES = 172;

  // One decoded result as it should appear on the output stream.
  typedef struct {
    logic [PRIME_W-1:0] prime;
    logic               prime_valid;
    logic               bad_code;
    logic               done_res;
    logic               last;
  } prime_result_t;

  // A row of the directed stimulus. Where has_exp is set, the number of
  // results and the prime of the last one were worked out by hand.
  typedef struct {
    logic [7:0]         data;
    bit                 has_exp;
    int                 exp_count;
    logic [PRIME_W-1:0] exp_prime;
  } byte_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [PRIME_W-1:0]    out_tdata;
  logic [2:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  prime_gap_prefix_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // The fixed codeword set. The half-gap of entry i is i+1 for the first
  // 166 entries; the last six entries skip values and are listed apart.
  string code_list [N_CODES] = '{
    "10001", "01111", "0101", "00011", "10011", "11011", "111101", "110001",
    "10101", "110011", "101101", "00001", "1110111", "001011", "111111",
    "0110101", "0110111", "001101", "0010011", "0110011", "1110101",
    "11100001", "10111011", "0110001", "10111101", "00111001", "11100101",
    "00100001", "101111111", "11100011", "001110101", "001110111",
    "00100011", "1110011011", "001111111", "101110001", "1011100101",
    "0011110111", "001111001", "0011111001", "11100110001", "1110011101",
    "00111110111", "10111110001", "1011100111", "111001111101",
    "111001111001", "10111110101", "101111101111", "111001100111",
    "00111101011", "001111010001", "1110011110111", "111001100101",
    "1110011111111", "1011111011011", "001111101011", "0011110100111",
    "0011110100101", "001111101001", "10111110011101", "10111110110001",
    "1011111001101", "111001111110111", "10111110010111", "11100111111001",
    "101111101100111", "101111100111111", "10111110010101",
    "111001111010011", "1110011111101011", "111001111010111",
    "1011111011001011", "1110011110100011", "111001111010101",
    "1011111001001001", "1011111001111011", "101111100100001",
    "11100111101000011", "1011111001000101", "1011111001111001",
    "10111110010011101", "10111110010001111", "1011111001001101",
    "10111110010010101", "111001111110100001", "11100111101000001",
    "101111101100100101", "101111100100101111", "10111110110010001",
    "101111100100011011", "1110011111101001001", "101111101100100111",
    "1011111001001111001", "1110011111101001011", "101111100100011001",
    "11100111111010011011", "11100111111010011101", "1110011111101000111",
    "11100111111010001011", "10111110010011111101", "1011111001001011011",
    "111001111110100111101", "10111110010010110011", "1011111001001111101",
    "101111100100111101001", "101111100100111101011",
    "111001111110100111111", "101111100100101100001",
    "101111100100111111101", "111001111110100010011",
    "1110011111101001100001", "1011111001001111011111",
    "101111100100111101101", "1011111001001111111101",
    "11100111111010011001001", "1110011111101001100111",
    "11100111111010001000011", "11100111111010011000111",
    "1011111001001111111111", "10111110010010110001001",
    "10111110010010110001011", "11100111111010001000101",
    "111001111110100110001011", "111001111110100010000011",
    "11100111111010001000111", "1110011111101001100101101",
    "101111100100101100011001", "10111110010010110001111",
    "101111100100111101110011", "1110011111101000100000001",
    "101111100100111101110001", "1110011111101001100010011",
    "11100111111010011001011101", "101111100100111101110111",
    "11100111111010011001010101", "11100111111010011001010011",
    "1110011111101001100010001", "10111110010011110111010011",
    "1011111001001011000110101", "11100111111010011001011111",
    "111001111110100010000001111", "10111110010011110111010101",
    "10111110010011110111010111", "11100111111010001000000101",
    "1110011111101001100101000011", "10111110010010110001101111",
    "1110011111101001100101000101", "11100111111010011001010111101",
    "10111110010010110001101101", "11100111111010011001010111111",
    "1011111001001111011101000101", "1110011111101001100101011101",
    "11100111111010001000000110001", "11100111111010001000000110011",
    "1011111001001111011101000001", "111001111110100110010100000111",
    "1110011111101001100101011011101", "1110011111101001100101000111",
    "11100111111010011001010110001", "11100111111010001000000110101",
    "1110011111101001100101011011111", "11100111111010001000000110111",
    "111001111110100110010101100101", "1011111001001111011101000011",
    "11100111111010011001010000001", "111001111110100110010101100111",
    "1011111001001111011101000111", "111001111110100110010101101001",
    "111001111110100110010101101011", "111001111110100110010101101101",
    "111001111110100110010100000101"
  };
  int tail_halves [6] = '{168, 170, 171, 173, 177, 191};
  int half_of [string];

  // Decoder state as the testbench predicts it.
  logic [LIMIT_W-1:0] limit_reg;
  logic [PRIME_W-1:0] first_reg;
  logic [RUN_W-1:0]   run_limit_reg;
  string              code_prefix;
  logic [PRIME_W-1:0] prime_sum;
  logic [LIMIT_W-1:0] primes_left;
  logic [7:0]         last_byte;
  int                 same_count;
  bit                 halted;

  prime_result_t pending_primes [$];
  int            error_count;
  int            cycle_count;
  bit            rx_burst;
  bit            tx_burst;

  // Bits of well-formed codeword streams waiting to be packed into bytes.
  bit            code_bits [$];

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Appends one predicted result; returns nothing, the caller fixes up flags.
  function automatic void push_result(logic valid, logic bad, logic done);
    prime_result_t r;
    r.prime       = prime_sum;
    r.prime_valid = valid;
    r.bad_code    = bad;
    r.done_res    = done;
    r.last        = 1'b0;
    pending_primes.insert(pending_primes.size(), r);
  endfunction

  // Predicts the results of one accepted byte and queues them; returns
  // how many were produced.
  function automatic int decode_byte(logic [7:0] b);
    int produced;
    int half;
    produced = 0;
    if (halted) return 0;
    if (b != last_byte) same_count = 0;
    if (same_count < 127) same_count++;
    last_byte = b;
    for (int i = 7; i >= 0 && !halted; i--) begin
      code_prefix = {code_prefix, b[i] ? "1" : "0"};
      if (code_prefix.len() > 31) begin
        // Overlong prefix: the whole prefix is thrown away and flagged.
        code_prefix = "";
        push_result(1'b0, 1'b1, 1'b0);
        produced++;
      end else if (half_of.exists(code_prefix)) begin
        half = half_of[code_prefix];
        code_prefix = "";
        prime_sum = prime_sum + PRIME_W'(2 * half);
        if (primes_left <= 1) begin
          primes_left = '0;
          halted = 1'b1;
        end else begin
          primes_left = primes_left - 1'b1;
        end
        push_result(1'b1, 1'b0, halted);
        produced++;
      end
    end
    if (!halted && same_count >= int'(run_limit_reg)) begin
      halted = 1'b1;
      if (produced > 0) begin
        pending_primes[pending_primes.size() - 1].done_res = 1'b1;
      end else begin
        push_result(1'b0, 1'b0, 1'b1);
        produced++;
      end
    end
    if (produced > 0) pending_primes[pending_primes.size() - 1].last = 1'b1;
    return produced;
  endfunction

  // Register write on the plain configuration port, called at a falling edge
  // while the block is idle; the predicted state follows the same rules.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      REG_PRIME_LIMIT: begin
        limit_reg   = value[LIMIT_W-1:0];
        primes_left = limit_reg;
      end
      REG_FIRST_PRIME: begin
        first_reg = value[PRIME_W-1:0];
        prime_sum = first_reg;
      end
      REG_RUN_LIMIT: run_limit_reg = value[RUN_W-1:0];
      default: ;
    endcase
  endtask

  // Sends one byte as an input transaction and returns the number of results
  // the predictor expects from it. Entered and left at a falling edge.
  task automatic send_byte(logic [7:0] b, output int produced);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    produced = decode_byte(b);
    @(negedge clk);
  endtask

  // Waits until every predicted result has come out, then lets the engine
  // finish any byte that yields nothing before the registers are touched.
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending_primes.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Next random byte: mostly packed codewords, with noise and short runs of
  // a repeated byte mixed in.
  function automatic logic [7:0] next_byte();
    logic [7:0] b;
    int         pick;
    string      cw;
    pick = $urandom_range(0, 15);
    if (pick == 0) return last_byte;
    if (pick == 1) return 8'($urandom_range(0, 255));
    while (code_bits.size() < 8) begin
      if ($urandom_range(0, 9) == 0) begin
        // A stray bit breaks the codeword alignment.
        code_bits.insert(code_bits.size(), 1'($urandom_range(0, 1)));
      end else begin
        cw = code_list[$urandom_range(0, N_CODES - 1)];
        for (int k = 0; k < cw.len(); k++)
          code_bits.insert(code_bits.size(), cw[k] == "1");
      end
    end
    for (int k = 7; k >= 0; k--) b[k] = code_bits.pop_front();
    return b;
  endfunction

  task automatic random_bytes(int count);
    int n;
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      if (i % 32 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      b = next_byte();
      // Short runs of one byte value keep the equal-byte counter busy.
      if ($urandom_range(0, 40) == 0) begin
        repeat ($urandom_range(2, 12)) send_byte(b, n);
      end else begin
        send_byte(b, n);
      end
    end
    tx_burst = 1'b0;
  endtask

  // Output side: each accepted result transaction is compared with the
  // oldest prediction.
  always @(posedge clk) begin
    prime_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_primes.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: prime=%0d tuser=%b last=%b",
                   out_tdata, out_tuser, out_tlast);
      end else begin
        e = pending_primes.pop_front();
        if (out_tdata !== e.prime || out_tuser[0] !== e.prime_valid ||
            out_tuser[1] !== e.bad_code || out_tuser[2] !== e.done_res ||
            out_tlast !== e.last) begin
          error_count++;
          if (error_count <= 10)
            $display({"mismatch: exp prime=%0d v=%b bad=%b done=%b last=%b, ",
                      "got prime=%0d v=%b bad=%b done=%b last=%b"},
                     e.prime, e.prime_valid, e.bad_code, e.done_res, e.last,
                     out_tdata, out_tuser[0], out_tuser[1], out_tuser[2],
                     out_tlast);
        end
      end
    end
  end

  // The receiver stalls a random number of cycles after each result, with
  // stretches of back-to-back acceptance.
  initial begin
    int hold;
    int taken;
    hold  = 0;
    taken = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_tready && out_tvalid) begin
        taken++;
        if (taken % 24 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        hold = rx_burst ? 0 : $urandom_range(0, 5);
      end else if (hold > 0) begin
        hold--;
      end
      out_tready = rst_n && (hold == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("prime_gap_prefix_decoder test failed");
      $finish;
    end
  end

  // Directed bytes after reset. Two 0x55 bytes each hold two 4-bit codes of
  // half-gap 3, so the prime steps 3, 9, 15, 21, 27. Four zero bytes then
  // grow a prefix that no codeword starts with, and the 32nd bit discards it.
  byte_row_t directed [20] = '{
    '{8'h55, 1'b1, 2, 48'd15}, '{8'h55, 1'b1, 2, 48'd27},
    '{8'h00, 1'b1, 0, 48'd0},  '{8'h00, 1'b1, 0, 48'd0},
    '{8'h00, 1'b1, 0, 48'd0},  '{8'h00, 1'b1, 1, 48'd27},
    '{8'hFF, 1'b0, 0, 48'd0},  '{8'h80, 1'b0, 0, 48'd0},
    '{8'h01, 1'b0, 0, 48'd0},  '{8'h7F, 1'b0, 0, 48'd0},
    '{8'hAA, 1'b0, 0, 48'd0},  '{8'h0F, 1'b0, 0, 48'd0},
    '{8'hF0, 1'b0, 0, 48'd0},  '{8'hE7, 1'b0, 0, 48'd0},
    '{8'hE9, 1'b0, 0, 48'd0},  '{8'h94, 1'b0, 0, 48'd0},
    '{8'h05, 1'b0, 0, 48'd0},  '{8'hBE, 1'b0, 0, 48'd0},
    '{8'h4F, 1'b0, 0, 48'd0},  '{8'h7A, 1'b0, 0, 48'd0}
  };

  initial begin
    int         n;
    int         stop_mode;
    logic [7:0] run_byte;
    for (int i = 0; i < N_CODES; i++)
      half_of[code_list[i]] = (i < 166) ? i + 1 : tail_halves[i - 166];

    // Predicted state after reset.
    limit_reg     = PRIME_LIMIT_RST;
    first_reg     = FIRST_PRIME_RST;
    run_limit_reg = RUN_LIMIT_RST;
    code_prefix   = "";
    prime_sum     = FIRST_PRIME_RST;
    primes_left   = PRIME_LIMIT_RST;
    last_byte     = 8'h00;
    same_count    = 0;
    halted        = 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    rx_burst      = 1'b0;
    tx_burst      = 1'b0;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    cfg_we    = 1'b0;
    cfg_addr  = REG_PRIME_LIMIT;
    cfg_wdata = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part on the reset register values.
    foreach (directed[i]) begin
      send_byte(directed[i].data, n);
      if (directed[i].has_exp && (n != directed[i].exp_count ||
          (n > 0 && pending_primes[pending_primes.size() - 1].prime !==
           directed[i].exp_prime))) begin
        error_count++;
        if (error_count <= 10)
          $display("row %0d: expected %0d results ending at prime %0d, predicted %0d",
                   i, directed[i].exp_count, directed[i].exp_prime, n);
      end
    end
    wait_idle();

    // Largest count limit and a start just below the wrap point, so the
    // running prime rolls over 2^48 early in this phase.
    write_reg(REG_PRIME_LIMIT, CFG_DATA_W'(24'hFFFFFF));
    write_reg(REG_FIRST_PRIME, {PRIME_W{1'b1}});
    write_reg(REG_RUN_LIMIT, CFG_DATA_W'(RUN_COUNT_MAX));
    random_bytes(150);
    wait_idle();

    write_reg(REG_FIRST_PRIME, '0);
    write_reg(REG_RUN_LIMIT, CFG_DATA_W'($urandom_range(40, 126)));
    random_bytes(150);
    wait_idle();

    write_reg(REG_PRIME_LIMIT, CFG_DATA_W'($urandom_range(5000, 24'hFFFFFF)));
    write_reg(REG_FIRST_PRIME, CFG_DATA_W'({$urandom(), $urandom()}));
    write_reg(REG_RUN_LIMIT, CFG_DATA_W'($urandom_range(40, 127)));
    random_bytes(150);
    wait_idle();

    // Closing phase: decoding stops once, by count or by a run of equal
    // bytes; the bytes sent after that must produce nothing.
    stop_mode = $urandom_range(0, 3);
    case (stop_mode)
      0: write_reg(REG_PRIME_LIMIT, CFG_DATA_W'(1));
      1: write_reg(REG_PRIME_LIMIT, CFG_DATA_W'($urandom_range(2, 20)));
      2: write_reg(REG_RUN_LIMIT, CFG_DATA_W'(1));
      default: write_reg(REG_RUN_LIMIT, CFG_DATA_W'($urandom_range(2, 10)));
    endcase
    run_byte = 8'($urandom_range(0, 255));
    repeat (12) send_byte(run_byte, n);
    random_bytes(30);
    wait_idle();

    if (error_count == 0) begin
      $display("prime_gap_prefix_decoder test passed");
    end else begin
      $display("prime_gap_prefix_decoder test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/pgpd_pkg.sv
sv/pgpd_front.sv
sv/pgpd_queue.sv
sv/pgpd_back.sv
sv/prime_gap_prefix_decoder.sv
tb/tb_prime_gap_prefix_decoder.sv
